FILE: rtl/vast_pkg.sv
// Package with shared types and constants of the voltage-alarm subscription table.
package vast_pkg;

  localparam int MaxEntries = 8;
  localparam int Phases = 3;
  localparam int NumLimits = 3;

  typedef enum logic [2:0] {
    CMD_REGISTER  = 3'd0,
    CMD_UNSUB     = 3'd1,
    CMD_CLEAR     = 3'd2,
    CMD_POP       = 3'd3,
    CMD_ACK_UNBLK = 3'd4,
    CMD_ACK_REM   = 3'd5,
    CMD_SAMPLE    = 3'd6,
    CMD_UNUSED    = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_BAD      = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  localparam logic [2:0] RegUnder0 = 3'd0;
  localparam logic [2:0] RegOver0  = 3'd3;
  localparam logic [2:0] RegEnable = 3'd6;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  phase;
    logic        alarm_type;
    logic [15:0] queue_handle;
    logic [7:0]  sub_id;
    logic [31:0] msg_id;
    logic [23:0] voltage;
    logic [31:0] time_now;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_sub_id;
    logic [15:0] out_queue;
    logic [31:0] out_msg_id;
    logic [31:0] out_time;
    logic [3:0]  total_count;
    logic [3:0]  active_count;
  } out_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SHIFT,
    BK_COUNT,
    BK_RESULT
  } bk_state_t;

endpackage

FILE: rtl/vast_front.sv
// Front part: accepts transactions and holds them in a two-entry queue.
module vast_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vast_pkg::in_item_t in_data,
  output logic               q_valid,
  input  logic               q_take,
  output vast_pkg::in_item_t q_data
);

  vast_pkg::in_item_t buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign pop  = q_take && q_valid;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = buf_r[rd_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_r] <= in_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");

endmodule

FILE: rtl/vast_back.sv
// Back part: executes one command at a time over the subscription table.
module vast_back #(
  parameter int MAX_ENTRIES = vast_pkg::MaxEntries,
  parameter int PHASES = vast_pkg::Phases
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_take,
  input  vast_pkg::in_item_t  q_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_wdata,
  output logic                out_valid,
  input  logic                out_stall,
  output vast_pkg::out_item_t out_data
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  // Entry storage; entries above the count hold stale data.
  logic [1:0]  e_phase_r [MAX_ENTRIES];
  logic        e_type_r  [MAX_ENTRIES];
  logic [15:0] e_queue_r [MAX_ENTRIES];
  logic [7:0]  e_id_r    [MAX_ENTRIES];
  logic        e_act_r   [MAX_ENTRIES];
  logic [31:0] e_msg_r   [MAX_ENTRIES];

  logic [23:0] under_r [vast_pkg::NumLimits];
  logic [23:0] over_r  [vast_pkg::NumLimits];
  logic [5:0]  en_r;
  logic [23:0] pv_r [vast_pkg::NumLimits];
  logic [31:0] msgc_r;
  logic [CW-1:0] count_r;

  vast_pkg::bk_state_t st_r, st_nxt;
  vast_pkg::in_item_t  cur_r;
  logic [CW-1:0] k_r;
  logic [CW-1:0] act_r;
  logic [7:0]  mx_r;
  logic        dup_r;
  logic [7:0]  rm_id_r;
  logic        rm_pend_r;
  vast_pkg::out_item_t res_r;
  logic        ov_r;

  logic [IW-1:0] ki, kn;
  logic [1:0]  ep;
  logic [23:0] vsel, usel, osel;
  logic        due, blk_hit, scan_end;

  assign ki = k_r[IW-1:0];
  assign kn = IW'(k_r + CW'(1));
  assign ep = e_phase_r[ki];
  assign scan_end = (k_r >= count_r);
  assign vsel = pv_r[(ep == 2'd3) ? 2'd0 : ep];
  assign usel = under_r[(ep == 2'd3) ? 2'd0 : ep];
  assign osel = over_r[(ep == 2'd3) ? 2'd0 : ep];
  assign blk_hit = !e_act_r[ki] && (e_msg_r[ki] == cur_r.msg_id);

  // Due test of the entry under the scan pointer.
  always_comb begin
    due = 1'b0;
    if (e_act_r[ki] && ep != 2'd3) begin
      if (!e_type_r[ki] && en_r[ep]) due = vsel < usel;
      else if (e_type_r[ki] && en_r[3'(ep) + 3'd3]) due = vsel > osel;
    end
  end

  assign q_take = (st_r == vast_pkg::BK_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data = res_r;

  // Next state: a scan ends at the table end or at the entry that settles the command.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      vast_pkg::BK_IDLE:   if (q_valid && !ov_r) st_nxt = vast_pkg::BK_SCAN;
      vast_pkg::BK_SCAN: begin
        case (vast_pkg::cmd_t'(cur_r.cmd))
          vast_pkg::CMD_REGISTER: begin
            if (count_r >= CW'(MAX_ENTRIES) || 32'(cur_r.phase) >= 32'(PHASES) || scan_end)
              st_nxt = vast_pkg::BK_COUNT;
          end
          vast_pkg::CMD_UNSUB, vast_pkg::CMD_ACK_UNBLK, vast_pkg::CMD_ACK_REM: begin
            if (rm_pend_r) begin
              if (scan_end) st_nxt = vast_pkg::BK_COUNT;
              else if (e_id_r[ki] == rm_id_r) st_nxt = vast_pkg::BK_SHIFT;
            end else if (scan_end) begin
              st_nxt = vast_pkg::BK_COUNT;
            end else if (cur_r.cmd == vast_pkg::CMD_UNSUB) begin
              if (e_id_r[ki] == cur_r.sub_id) st_nxt = vast_pkg::BK_SHIFT;
            end else if (blk_hit && cur_r.cmd == vast_pkg::CMD_ACK_UNBLK) begin
              st_nxt = vast_pkg::BK_COUNT;
            end
          end
          vast_pkg::CMD_POP: if (scan_end || due) st_nxt = vast_pkg::BK_COUNT;
          default:           st_nxt = vast_pkg::BK_COUNT;
        endcase
      end
      vast_pkg::BK_SHIFT:  if (!(k_r + CW'(1) < count_r)) st_nxt = vast_pkg::BK_COUNT;
      vast_pkg::BK_COUNT:  if (scan_end) st_nxt = vast_pkg::BK_RESULT;
      vast_pkg::BK_RESULT: st_nxt = vast_pkg::BK_IDLE;
      default:             st_nxt = vast_pkg::BK_IDLE;
    endcase
  end

  // Control and table updates; scan and shift steps handle one entry a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= vast_pkg::BK_IDLE;
      ov_r <= 1'b0;
      count_r <= '0;
      msgc_r <= 32'd1;
      en_r <= '0;
      for (int i = 0; i < vast_pkg::NumLimits; i++) begin
        under_r[i] <= '0;
        over_r[i] <= '0;
        pv_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index < vast_pkg::RegOver0) under_r[2'(cfg_index)] <= cfg_wdata;
        else if (cfg_index < vast_pkg::RegEnable)
          over_r[2'(cfg_index - vast_pkg::RegOver0)] <= cfg_wdata;
        else if (cfg_index == vast_pkg::RegEnable) en_r <= cfg_wdata[5:0];
      end
      case (st_r)
        vast_pkg::BK_IDLE: begin
          if (q_valid && !ov_r) begin
            cur_r <= q_data;
            k_r <= '0;
            mx_r <= 8'd0;
            dup_r <= 1'b0;
            rm_pend_r <= 1'b0;
            res_r <= '{status: vast_pkg::ST_OK, default: '0};
          end
        end
        vast_pkg::BK_SCAN: begin
          case (vast_pkg::cmd_t'(cur_r.cmd))
            vast_pkg::CMD_REGISTER: begin
              if (count_r >= CW'(MAX_ENTRIES)) begin
                res_r.status <= vast_pkg::ST_FULL;
                k_r <= '0; act_r <= '0;
              end else if (32'(cur_r.phase) >= 32'(PHASES)) begin
                res_r.status <= vast_pkg::ST_BAD;
                k_r <= '0; act_r <= '0;
              end else if (scan_end) begin
                if (dup_r) res_r.status <= vast_pkg::ST_EXISTS;
                else begin
                  e_phase_r[k_r[IW-1:0]] <= cur_r.phase;
                  e_type_r[k_r[IW-1:0]] <= cur_r.alarm_type;
                  e_queue_r[k_r[IW-1:0]] <= cur_r.queue_handle;
                  e_id_r[k_r[IW-1:0]] <= mx_r + 8'd1;
                  e_act_r[k_r[IW-1:0]] <= 1'b1;
                  e_msg_r[k_r[IW-1:0]] <= '0;
                  count_r <= count_r + CW'(1);
                  res_r.out_sub_id <= mx_r + 8'd1;
                end
                k_r <= '0; act_r <= '0;
              end else begin
                if (ep == cur_r.phase && e_type_r[ki] == cur_r.alarm_type &&
                    e_queue_r[ki] == cur_r.queue_handle) dup_r <= 1'b1;
                if (e_id_r[ki] > mx_r) mx_r <= e_id_r[ki];
                k_r <= k_r + CW'(1);
              end
            end
            vast_pkg::CMD_UNSUB, vast_pkg::CMD_ACK_UNBLK, vast_pkg::CMD_ACK_REM: begin
              if (rm_pend_r) begin
                // Second pass of ack remove: find first entry with that id.
                if (scan_end) begin
                  k_r <= '0; act_r <= '0;
                end else if (e_id_r[ki] != rm_id_r) k_r <= k_r + CW'(1);
              end else if (scan_end) begin
                res_r.status <= vast_pkg::ST_NOTFOUND;
                k_r <= '0; act_r <= '0;
              end else if (cur_r.cmd == vast_pkg::CMD_UNSUB) begin
                if (e_id_r[ki] != cur_r.sub_id) k_r <= k_r + CW'(1);
              end else if (blk_hit) begin
                if (cur_r.cmd == vast_pkg::CMD_ACK_UNBLK) begin
                  e_act_r[ki] <= 1'b1;
                  k_r <= '0; act_r <= '0;
                end else begin
                  rm_id_r <= e_id_r[ki];
                  rm_pend_r <= 1'b1;
                  k_r <= '0;
                end
              end else k_r <= k_r + CW'(1);
            end
            vast_pkg::CMD_CLEAR: begin
              count_r <= '0;
              k_r <= '0; act_r <= '0;
            end
            vast_pkg::CMD_POP: begin
              if (scan_end) begin
                res_r.status <= vast_pkg::ST_NOTFOUND;
                k_r <= '0; act_r <= '0;
              end else if (due) begin
                msgc_r <= msgc_r + 32'd1;
                e_act_r[ki] <= 1'b0;
                e_msg_r[ki] <= msgc_r + 32'd1;
                res_r.out_sub_id <= e_id_r[ki];
                res_r.out_queue <= e_queue_r[ki];
                res_r.out_msg_id <= msgc_r + 32'd1;
                res_r.out_time <= cur_r.time_now;
                k_r <= '0; act_r <= '0;
              end else k_r <= k_r + CW'(1);
            end
            vast_pkg::CMD_SAMPLE: begin
              if (32'(cur_r.phase) < 32'(PHASES) && cur_r.phase != 2'd3)
                pv_r[cur_r.phase] <= cur_r.voltage;
              else res_r.status <= vast_pkg::ST_BAD;
              k_r <= '0; act_r <= '0;
            end
            default: begin
              res_r.status <= vast_pkg::ST_BAD;
              k_r <= '0; act_r <= '0;
            end
          endcase
        end
        vast_pkg::BK_SHIFT: begin
          // Close the gap one slot a cycle.
          if (k_r + CW'(1) < count_r) begin
            e_phase_r[ki] <= e_phase_r[kn];
            e_type_r[ki] <= e_type_r[kn];
            e_queue_r[ki] <= e_queue_r[kn];
            e_id_r[ki] <= e_id_r[kn];
            e_act_r[ki] <= e_act_r[kn];
            e_msg_r[ki] <= e_msg_r[kn];
            k_r <= k_r + CW'(1);
          end else begin
            count_r <= count_r - CW'(1);
            k_r <= '0; act_r <= '0;
          end
        end
        vast_pkg::BK_COUNT: begin
          if (!scan_end) begin
            if (e_act_r[ki]) act_r <= act_r + CW'(1);
            k_r <= k_r + CW'(1);
          end
        end
        vast_pkg::BK_RESULT: begin
          res_r.total_count <= 4'(count_r);
          res_r.active_count <= 4'(act_r);
          ov_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES)) else $error("entry count beyond table size");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> st_r == vast_pkg::BK_IDLE) else $error("take while busy");
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == vast_pkg::BK_RESULT |=> ov_r) else $error("result not presented");

endmodule

FILE: rtl/voltage_alarm_subscription_table_core.sv
// Top level of the voltage-alarm subscription table.
// Usage:
// The in_ channel carries one command transaction (register, unsubscribe, clear,
// pop, ack unblock, ack remove, voltage sample); each gives exactly one result
// transaction on the out_ channel, in order. The user must write thresholds and
// enables through cfg_ only while the block is idle; the block does not check.
// A two-entry queue separates the front from the back, so the input side keeps
// accepting while the back works or a result waits.
// From input acceptance to out_valid a command passes the scan, the shift for a
// removal, the recount of active entries and the result state. An ack remove
// scans twice, shifts the table one slot a cycle and recounts active entries one
// entry a cycle. The back takes the next command in the cycle after its result
// is accepted, so it does not take a new command before the last one is done.
// Reset empties the table, clears thresholds and voltages, sets the message
// counter to one. When out_stall is high the result holds and the back waits;
// the queue then fills and in_stall rises.
module voltage_alarm_subscription_table_core #(
  parameter int MAX_ENTRIES = vast_pkg::MaxEntries,
  parameter int PHASES = vast_pkg::Phases
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vast_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output vast_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_wdata
);

  logic q_valid, q_take;
  vast_pkg::in_item_t q_data;

  vast_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_take, .q_data
  );

  vast_back #(.MAX_ENTRIES(MAX_ENTRIES), .PHASES(PHASES)) u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_data,
    .cfg_we, .cfg_index, .cfg_wdata,
    .out_valid, .out_stall, .out_data
  );

endmodule

FILE: test/tb_voltage_alarm_subscription_table_core.sv
// Self-checking testbench of the voltage-alarm subscription table with its own table predictor.
module tb_voltage_alarm_subscription_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int RandItems = 1200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  vast_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  vast_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_wdata = '0;

  voltage_alarm_subscription_table_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table, thresholds and counters.
  logic [23:0] lim_under [3];
  logic [23:0] lim_over [3];
  logic [5:0] lim_en;
  int unsigned tab_n;
  logic [1:0] tab_phase [vast_pkg::MaxEntries];
  logic tab_type [vast_pkg::MaxEntries];
  logic [15:0] tab_queue [vast_pkg::MaxEntries];
  logic [7:0] tab_ident [vast_pkg::MaxEntries];
  logic tab_active [vast_pkg::MaxEntries];
  logic [31:0] tab_msg [vast_pkg::MaxEntries];
  logic [23:0] volt_seen [3];
  logic [31:0] msg_ctr;

  vast_pkg::in_item_t pending_cmds[$];
  vast_pkg::out_item_t expected_results[$];
  int mismatches = 0;
  int unsigned cycles = 0;
  int unsigned accepted = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  logic in_stall_q = 1'b1;

  function automatic void table_reset();
    for (int k = 0; k < 3; k++) begin
      lim_under[k] = '0;
      lim_over[k] = '0;
      volt_seen[k] = '0;
    end
    lim_en = '0;
    tab_n = 0;
    msg_ctr = 32'd1;
  endfunction

  function automatic void drop_entry(int unsigned k);
    for (int unsigned j = k; j + 1 < tab_n; j++) begin
      tab_phase[j] = tab_phase[j+1];
      tab_type[j] = tab_type[j+1];
      tab_queue[j] = tab_queue[j+1];
      tab_ident[j] = tab_ident[j+1];
      tab_active[j] = tab_active[j+1];
      tab_msg[j] = tab_msg[j+1];
    end
    tab_n--;
  endfunction

  function automatic bit remove_ident(logic [7:0] id);
    for (int unsigned k = 0; k < tab_n; k++) begin
      if (tab_ident[k] == id) begin
        drop_entry(k);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit alarm_due(int unsigned k);
    int unsigned p;
    p = tab_phase[k];
    if (!tab_active[k] || p >= 3) return 1'b0;
    if (tab_type[k] == 1'b0 && lim_en[p]) return volt_seen[p] < lim_under[p];
    if (tab_type[k] == 1'b1 && lim_en[3+p]) return volt_seen[p] > lim_over[p];
    return 1'b0;
  endfunction

  function automatic int find_blocked(logic [31:0] msg);
    for (int unsigned k = 0; k < tab_n; k++)
      if (!tab_active[k] && tab_msg[k] == msg) return int'(k);
    return -1;
  endfunction

  // Apply one command to the shadow table and return the result it should produce.
  function automatic vast_pkg::out_item_t table_apply(vast_pkg::in_item_t c);
    vast_pkg::out_item_t r;
    bit dup;
    logic [7:0] mx;
    int f;
    int unsigned act;
    r = '0;
    r.status = vast_pkg::ST_OK;
    case (vast_pkg::cmd_t'(c.cmd))
      vast_pkg::CMD_REGISTER: begin
        if (tab_n >= vast_pkg::MaxEntries) r.status = vast_pkg::ST_FULL;
        else if (c.phase >= vast_pkg::Phases) r.status = vast_pkg::ST_BAD;
        else begin
          dup = 1'b0;
          mx = '0;
          for (int unsigned k = 0; k < tab_n; k++) begin
            if (tab_phase[k] == c.phase && tab_type[k] == c.alarm_type &&
                tab_queue[k] == c.queue_handle) dup = 1'b1;
            if (tab_ident[k] > mx) mx = tab_ident[k];
          end
          if (dup) r.status = vast_pkg::ST_EXISTS;
          else begin
            tab_phase[tab_n] = c.phase;
            tab_type[tab_n] = c.alarm_type;
            tab_queue[tab_n] = c.queue_handle;
            tab_ident[tab_n] = mx + 8'd1;
            tab_active[tab_n] = 1'b1;
            tab_msg[tab_n] = '0;
            r.out_sub_id = mx + 8'd1;
            tab_n++;
          end
        end
      end
      vast_pkg::CMD_UNSUB:
        r.status = remove_ident(c.sub_id) ? vast_pkg::ST_OK : vast_pkg::ST_NOTFOUND;
      vast_pkg::CMD_CLEAR: tab_n = 0;
      vast_pkg::CMD_POP: begin
        r.status = vast_pkg::ST_NOTFOUND;
        for (int unsigned k = 0; k < tab_n; k++) begin
          if (alarm_due(k)) begin
            msg_ctr = msg_ctr + 32'd1;
            tab_active[k] = 1'b0;
            tab_msg[k] = msg_ctr;
            r.status = vast_pkg::ST_OK;
            r.out_sub_id = tab_ident[k];
            r.out_queue = tab_queue[k];
            r.out_msg_id = msg_ctr;
            r.out_time = c.time_now;
            break;
          end
        end
      end
      vast_pkg::CMD_ACK_UNBLK: begin
        f = find_blocked(c.msg_id);
        if (f >= 0) tab_active[f] = 1'b1;
        else r.status = vast_pkg::ST_NOTFOUND;
      end
      vast_pkg::CMD_ACK_REM: begin
        f = find_blocked(c.msg_id);
        if (f >= 0) void'(remove_ident(tab_ident[f]));
        else r.status = vast_pkg::ST_NOTFOUND;
      end
      vast_pkg::CMD_SAMPLE: begin
        if (c.phase < vast_pkg::Phases) volt_seen[c.phase] = c.voltage;
        else r.status = vast_pkg::ST_BAD;
      end
      default: r.status = vast_pkg::ST_BAD;
    endcase
    act = 0;
    for (int unsigned k = 0; k < tab_n; k++) if (tab_active[k]) act++;
    r.total_count = tab_n[3:0];
    r.active_count = act[3:0];
    return r;
  endfunction

  // Build a command of the given kind, every other field random; callers fix the chosen ones.
  function automatic vast_pkg::in_item_t make_cmd(vast_pkg::cmd_t op);
    vast_pkg::in_item_t c;
    c.cmd = op;
    c.phase = 2'($urandom_range(0, 3));
    c.alarm_type = 1'($urandom_range(0, 1));
    c.queue_handle = 16'($urandom);
    c.sub_id = 8'($urandom);
    c.msg_id = $urandom;
    c.voltage = 24'($urandom);
    c.time_now = $urandom;
    return c;
  endfunction

  // Recently stamped message ids and known ids make acks and unsubscribes hit.
  function automatic vast_pkg::in_item_t rand_cmd();
    vast_pkg::in_item_t c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      c = make_cmd(vast_pkg::CMD_REGISTER);
      if ($urandom_range(0, 9) != 0) c.phase = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 1)) c.queue_handle = 16'($urandom_range(0, 3));
    end else if (pick < 45) begin
      c = make_cmd(vast_pkg::CMD_SAMPLE);
      if ($urandom_range(0, 9) != 0) c.phase = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 2) == 0) c.voltage = 24'($urandom_range(0, 15)) << 20;
    end else if (pick < 70) c = make_cmd(vast_pkg::CMD_POP);
    else if (pick < 80) begin
      c = make_cmd(vast_pkg::CMD_ACK_UNBLK);
      if ($urandom_range(0, 4) != 0) c.msg_id = msg_ctr - 32'($urandom_range(0, 4));
    end else if (pick < 88) begin
      c = make_cmd(vast_pkg::CMD_ACK_REM);
      if ($urandom_range(0, 4) != 0) c.msg_id = msg_ctr - 32'($urandom_range(0, 4));
    end else if (pick < 96) begin
      c = make_cmd(vast_pkg::CMD_UNSUB);
      if ($urandom_range(0, 3) != 0) c.sub_id = 8'($urandom_range(0, 12));
    end else if (pick < 98) c = make_cmd(vast_pkg::CMD_CLEAR);
    else c = make_cmd(vast_pkg::CMD_UNUSED);
    return c;
  endfunction

  // Driver: presents pending commands with random gaps at the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_q) begin
        if (pending_cmds.size() > 0 && in_gap == 0) begin
          in_data <= pending_cmds.pop_front();
          in_gap = $urandom_range(0, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid && pending_cmds.size() > 0) begin
        if (in_gap == 0) begin
          in_valid <= 1'b1;
          in_data <= pending_cmds.pop_front();
          in_gap = $urandom_range(0, 4);
        end else in_gap--;
      end
      if (out_gap == 0) begin
        out_stall <= 1'b0;
        out_gap = $urandom_range(0, 4);
      end else begin
        out_stall <= 1'b1;
        out_gap--;
      end
    end
  end

  // Acceptance seen at the rising edge; the driver uses the flag on the next falling edge.
  always @(posedge clk) begin
    cycles++;
    in_stall_q <= !(in_valid && !in_stall);
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(table_apply(in_data));
      accepted++;
    end
  end

  // Monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin : monitor
    vast_pkg::out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction %p", out_data);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected %p, got %p", exp_r, out_data);
        end
      end
    end
  end

  // Queue a batch of random commands and wait until all their results are back.
  task automatic run_phase(int unsigned count, bit directed_regs);
    int unsigned target;
    target = accepted + pending_cmds.size() + count;
    for (int unsigned i = 0; i < count; i++) pending_cmds.push_back(rand_cmd());
    wait (accepted == target && !in_valid && expected_results.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx < 3) lim_under[idx] = val;
    else if (idx < 6) lim_over[idx-3] = val;
    else lim_en = val[5:0];
  endtask

  task automatic wait_drain();
    wait (pending_cmds.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic push(vast_pkg::in_item_t c);
    pending_cmds.push_back(c);
  endtask

  // Stop at a generous cycle limit.
  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    vast_pkg::in_item_t c;
    table_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Thresholds at mid range, all enabled.
    for (int k = 0; k < 3; k++) begin
      cfg_write(vast_pkg::RegUnder0 + 3'(k), 24'h800000);
      cfg_write(vast_pkg::RegOver0 + 3'(k), 24'h900000);
    end
    cfg_write(vast_pkg::RegEnable, 24'h3f);

    // Directed: bad phases, full table, pops, acks, unused command.
    c = make_cmd(vast_pkg::CMD_SAMPLE); c.phase = 2'd3; push(c);
    c = make_cmd(vast_pkg::CMD_REGISTER); c.phase = 2'd3; push(c);
    for (int k = 0; k < 8; k++) begin
      c = make_cmd(vast_pkg::CMD_REGISTER); c.phase = 2'(k % 3); c.alarm_type = k[0];
      c.queue_handle = (k == 7) ? 16'hffff : 16'(k); push(c);
    end
    c = make_cmd(vast_pkg::CMD_REGISTER); c.phase = 2'd0; c.queue_handle = 16'd0; push(c);
    c = make_cmd(vast_pkg::CMD_POP); push(c);
    c = make_cmd(vast_pkg::CMD_SAMPLE); c.phase = 2'd0; c.voltage = 24'd0; push(c);
    c = make_cmd(vast_pkg::CMD_SAMPLE); c.phase = 2'd1; c.voltage = 24'hffffff; push(c);
    c = make_cmd(vast_pkg::CMD_POP); c.time_now = 32'hffffffff; push(c);
    c = make_cmd(vast_pkg::CMD_POP); c.time_now = 32'd0; push(c);
    c = make_cmd(vast_pkg::CMD_ACK_UNBLK); c.msg_id = 32'd2; push(c);
    c = make_cmd(vast_pkg::CMD_ACK_REM); c.msg_id = 32'd3; push(c);
    c = make_cmd(vast_pkg::CMD_ACK_REM); c.msg_id = 32'hffffffff; push(c);
    c = make_cmd(vast_pkg::CMD_UNSUB); c.sub_id = 8'd1; push(c);
    c = make_cmd(vast_pkg::CMD_UNSUB); c.sub_id = 8'd200; push(c);
    c = make_cmd(vast_pkg::CMD_UNUSED); push(c);
    c = make_cmd(vast_pkg::CMD_CLEAR); push(c);
    wait_drain();

    // Random phases over several threshold settings, the extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      for (int k = 0; k < 3; k++) begin
        cfg_write(vast_pkg::RegUnder0 + 3'(k),
                  ph == 0 ? 24'd0 : ph == 1 ? 24'hffffff : 24'($urandom));
        cfg_write(vast_pkg::RegOver0 + 3'(k),
                  ph == 0 ? 24'hffffff : ph == 1 ? 24'd0 : 24'($urandom));
      end
      cfg_write(vast_pkg::RegEnable,
                ph == 0 ? 24'h00 : ph == 1 ? 24'h3f : 24'($urandom_range(0, 63)));
      for (int i = 0; i < RandItems / 6; i++) push(rand_cmd());
      wait_drain();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
